// ===== sv/pe_pkg.sv =====
// Package for the Paillier encrypt/decrypt block.
// Holds register indexes, reset values, opcodes and the shared-unit control types.
// No dependencies.
package pe_pkg;

	// Register reset values
	localparam logic [15:0] RST_MODULUS   = 16'd3233;
	localparam logic [31:0] RST_GENERATOR = 32'd3234;
	localparam logic [15:0] RST_LAMBDA    = 16'd780;
	localparam logic [15:0] RST_MU        = 16'd1173;
	localparam logic [31:0] RST_NONCE     = 32'd17;

	// Field widths
	localparam int MOD_REG_W  = 16;
	localparam int VALUE_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DEF_MOD_WIDTH = 16;

	// Operand width of the multiplier's serial input
	localparam int MM_BW = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULUS   = 3'd0,
		REG_GENERATOR = 3'd1,
		REG_LAMBDA    = 3'd2,
		REG_MU        = 3'd3,
		REG_NONCE     = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_ENC = 1'b0,
		OP_DEC = 1'b1
	} op_t;

	// Control into the modular multiplier
	typedef struct packed {
		logic start;
	} mm_ctl_t;

	// Status out of the modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mm_st_t;

endpackage

// ===== sv/pe_stream_if.sv =====
// Valid/ready channel interfaces for the Paillier block.
// Depends on pe_pkg for field widths.
interface pe_in_if;
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic [pe_pkg::VALUE_W-1:0] value;
	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface pe_out_if;
	logic                       valid;
	logic                       ready;
	logic [pe_pkg::VALUE_W-1:0] result;
	modport source (output valid, output result, input ready);
	modport sink   (input valid, input result, output ready);
endinterface

// ===== sv/pe_modmul.sv =====
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle, MSB first.
// With a = 1 it reduces b and also returns the quotient floor(b / m) in q.
// Depends on pe_pkg.
module pe_modmul #(
	parameter int SW = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pe_pkg::mm_ctl_t           ctl,
	input  logic [SW-1:0]             a,
	input  logic [pe_pkg::MM_BW-1:0]  b,
	input  logic [SW-1:0]             m,
	output pe_pkg::mm_st_t            st,
	output logic [SW-1:0]             r,
	output logic [pe_pkg::MM_BW-1:0]  q
);
	import pe_pkg::*;

	localparam int CW = $clog2(MM_BW);

	logic [SW-1:0]    a_q, m_q, acc_q;
	logic [MM_BW-1:0] b_q, q_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;

	logic [SW:0] dbl, d1, t, t1;
	logic        s1, s2;

	// Double, reduce, add the selected multiple, reduce again
	always_comb begin
		dbl = {acc_q, 1'b0};
		s1  = dbl >= {1'b0, m_q};
		d1  = s1 ? dbl - {1'b0, m_q} : dbl;
		t   = {1'b0, d1[SW-1:0]} + (b_q[MM_BW-1] ? {1'b0, a_q} : '0);
		s2  = t >= {1'b0, m_q};
		t1  = s2 ? t - {1'b0, m_q} : t;
	end

	// Load operands on start, then step one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MM_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			a_q   <= a;
			m_q   <= m;
			b_q   <= b;
			acc_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			acc_q <= t1[SW-1:0];
			b_q   <= {b_q[MM_BW-2:0], 1'b0};
			q_q   <= {q_q[MM_BW-2:0], s1 | s2};
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign r       = acc_q;
	assign q       = q_q;

endmodule

// ===== sv/paillier_encrypt_decrypt.sv =====
// Paillier encrypt/decrypt, one item at a time on one shared bit-serial modular multiplier.
// Encrypt raises g and r to their powers by square-and-multiply and multiplies the two; decrypt
// raises the ciphertext to lambda, reduces mu, then divides and multiplies. A zero power skips
// the divide and multiply, and a zero modulus goes straight to a zero result. A new item is
// taken only after the last result has been transferred.
// arst_n clears the sequencer and loads the default key registers and nonce.
module paillier_encrypt_decrypt #(
	parameter int MOD_WIDTH = pe_pkg::DEF_MOD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pe_pkg::CFG_DATA_W-1:0] cfg_data,
	pe_in_if.sink                         in_ch,
	pe_out_if.source                      out_ch
);
	import pe_pkg::*;

	localparam int NW = (MOD_WIDTH < MOD_REG_W) ? MOD_WIDTH : MOD_REG_W;
	localparam int SW = 2 * NW;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_CHK    = 13'b0000000000010,
		S_E_RG   = 13'b0000000000100,
		S_E_RR   = 13'b0000000001000,
		S_E_FIN  = 13'b0000000010000,
		S_D_RC   = 13'b0000000100000,
		S_D_MU   = 13'b0000001000000,
		S_D_DIV  = 13'b0000010000000,
		S_D_MUL  = 13'b0000100000000,
		S_PW     = 13'b0001000000000,
		S_PW_MUL = 13'b0010000000000,
		S_PW_SQR = 13'b0100000000000,
		S_OUT    = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		PH_G = 2'd0,
		PH_R = 2'd1,
		PH_C = 2'd2
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic [MOD_REG_W-1:0] mod_q, lambda_q, mu_reg_q;
	logic [VALUE_W-1:0]   gen_q, nonce_q, val_q, exp_q;
	logic                 op_q, wait_q;
	logic [SW-1:0]        nsq_q, acc_q, base_q, gm_q, mu_q, res_q;

	logic [NW-1:0] n_w;
	logic [SW-1:0] n_s, one_nsq, one_n;

	mm_ctl_t           mm_ctl;
	mm_st_t            mm_st;
	logic [SW-1:0]     mm_a, mm_m, mm_r;
	logic [MM_BW-1:0]  mm_b, mm_q;

	assign n_w     = mod_q[NW-1:0];
	assign n_s     = SW'(n_w);
	assign one_nsq = (nsq_q == SW'(1)) ? '0 : SW'(1);
	assign one_n   = (n_w == NW'(1)) ? '0 : SW'(1);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q    <= RST_MODULUS;
			gen_q    <= RST_GENERATOR;
			lambda_q <= RST_LAMBDA;
			mu_reg_q <= RST_MU;
			nonce_q  <= RST_NONCE;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_MODULUS:   mod_q    <= cfg_data[MOD_REG_W-1:0];
				REG_GENERATOR: gen_q    <= cfg_data;
				REG_LAMBDA:    lambda_q <= cfg_data[MOD_REG_W-1:0];
				REG_MU:        mu_reg_q <= cfg_data[MOD_REG_W-1:0];
				REG_NONCE:     nonce_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Select multiplier operands for the current step
	always_comb begin
		mm_a = one_nsq;
		mm_b = '0;
		mm_m = nsq_q;
		case (state_q)
			S_E_RG:   mm_b = gen_q;
			S_E_RR:   mm_b = nonce_q;
			S_D_RC:   mm_b = val_q;
			S_PW_MUL: begin
				mm_a = base_q;
				mm_b = MM_BW'(acc_q);
			end
			S_PW_SQR: begin
				mm_a = base_q;
				mm_b = MM_BW'(base_q);
			end
			S_E_FIN: begin
				mm_a = gm_q;
				mm_b = MM_BW'(acc_q);
			end
			S_D_MU: begin
				mm_a = one_n;
				mm_b = MM_BW'(mu_reg_q);
				mm_m = n_s;
			end
			S_D_DIV: begin
				mm_a = one_n;
				mm_b = MM_BW'(acc_q - SW'(1));
				mm_m = n_s;
			end
			S_D_MUL: begin
				mm_a = mu_q;
				mm_b = MM_BW'(base_q);
				mm_m = n_s;
			end
			default: ;
		endcase
	end

	assign mm_ctl.start = !wait_q && (state_q == S_E_RG || state_q == S_E_RR
		|| state_q == S_D_RC || state_q == S_PW_MUL || state_q == S_PW_SQR
		|| state_q == S_E_FIN || state_q == S_D_MU || state_q == S_D_DIV
		|| state_q == S_D_MUL);

	pe_modmul #(.SW(SW)) u_mm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mm_ctl),
		.a      (mm_a),
		.b      (mm_b),
		.m      (mm_m),
		.st     (mm_st),
		.r      (mm_r),
		.q      (mm_q)
	);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_G;
			wait_q  <= 1'b0;
		end else begin
			if (mm_ctl.start) begin
				wait_q <= 1'b1;
			end else if (mm_st.done) begin
				wait_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) state_q <= S_CHK;
				end
				S_CHK: begin
					if (n_w == '0) state_q <= S_OUT;
					else if (op_q == OP_ENC) state_q <= S_E_RG;
					else state_q <= S_D_RC;
				end
				S_E_RG: begin
					if (mm_st.done) begin
						phase_q <= PH_G;
						state_q <= S_PW;
					end
				end
				S_E_RR: begin
					if (mm_st.done) begin
						phase_q <= PH_R;
						state_q <= S_PW;
					end
				end
				S_D_RC: begin
					if (mm_st.done) begin
						phase_q <= PH_C;
						state_q <= S_PW;
					end
				end
				S_PW: begin
					if (exp_q == '0) begin
						case (phase_q)
							PH_G:    state_q <= S_E_RR;
							PH_R:    state_q <= S_E_FIN;
							default: state_q <= S_D_MU;
						endcase
					end else if (exp_q[0]) begin
						state_q <= S_PW_MUL;
					end else begin
						state_q <= S_PW_SQR;
					end
				end
				S_PW_MUL: if (mm_st.done) state_q <= S_PW_SQR;
				S_PW_SQR: if (mm_st.done) state_q <= S_PW;
				S_E_FIN:  if (mm_st.done) state_q <= S_OUT;
				S_D_MU: begin
					if (mm_st.done) state_q <= (acc_q == '0) ? S_OUT : S_D_DIV;
				end
				S_D_DIV: if (mm_st.done) state_q <= S_D_MUL;
				S_D_MUL: if (mm_st.done) state_q <= S_OUT;
				S_OUT:   if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_ch.valid) begin
					op_q  <= in_ch.opcode;
					val_q <= in_ch.value;
					nsq_q <= SW'({{NW{1'b0}}, n_w} * {{NW{1'b0}}, n_w});
				end
			end
			S_CHK: res_q <= '0;
			S_E_RG: begin
				if (mm_st.done) begin
					base_q <= mm_r;
					exp_q  <= val_q;
					acc_q  <= one_nsq;
				end
			end
			S_E_RR: begin
				if (mm_st.done) begin
					base_q <= mm_r;
					exp_q  <= VALUE_W'(n_w);
					acc_q  <= one_nsq;
				end
			end
			S_D_RC: begin
				if (mm_st.done) begin
					base_q <= mm_r;
					exp_q  <= VALUE_W'(lambda_q);
					acc_q  <= one_nsq;
				end
			end
			S_PW: begin
				if (exp_q == '0 && phase_q == PH_G) gm_q <= acc_q;
			end
			S_PW_MUL: if (mm_st.done) acc_q <= mm_r;
			S_PW_SQR: begin
				if (mm_st.done) begin
					base_q <= mm_r;
					exp_q  <= {1'b0, exp_q[VALUE_W-1:1]};
				end
			end
			S_E_FIN: if (mm_st.done) res_q <= mm_r;
			S_D_MU: begin
				if (mm_st.done) begin
					mu_q  <= mm_r;
					res_q <= (mm_r == '0) ? '0 : n_s - mm_r;
				end
			end
			S_D_DIV: if (mm_st.done) base_q <= mm_q[SW-1:0];
			S_D_MUL: if (mm_st.done) res_q <= mm_r;
			default: ;
		endcase
	end

	assign in_ch.ready   = (state_q == S_IDLE);
	assign out_ch.valid  = (state_q == S_OUT);
	assign out_ch.result = VALUE_W'(res_q);

`ifndef SYNTH
	// One item at a time: never take input while a result is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input ready while result pending");

	// A transfer in is never answered in the next cycle
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !out_ch.valid)
		else $error("result offered right after input transfer");

	// The multiplier only finishes work the sequencer started
	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mm_st.done |-> wait_q)
		else $error("multiplier done without a pending request");

	// Decrypt results lie below the modulus
	a_dec_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && op_q == OP_DEC && n_w != '0) |-> (res_q < n_s))
		else $error("decrypt result not below modulus");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the Paillier encrypt/decrypt block.
// A scoreboard class predicts each ciphertext or plaintext from its own copy of the keys.
// Depends on pe_pkg, pe_stream_if.sv and paillier_encrypt_decrypt.
class paillier_scoreboard;
	logic [15:0] modulus;
	logic [31:0] generator;
	logic [15:0] lambda;
	logic [15:0] mu;
	logic [31:0] nonce;
	logic [31:0] expected_results[$];
	int mismatches;

	function new();
		modulus   = pe_pkg::RST_MODULUS;
		generator = pe_pkg::RST_GENERATOR;
		lambda    = pe_pkg::RST_LAMBDA;
		mu        = pe_pkg::RST_MU;
		nonce     = pe_pkg::RST_NONCE;
		mismatches = 0;
	endfunction

	function void set_reg(pe_pkg::reg_idx_t idx, logic [31:0] data);
		case (idx)
			pe_pkg::REG_MODULUS:   modulus = data[15:0];
			pe_pkg::REG_GENERATOR: generator = data;
			pe_pkg::REG_LAMBDA:    lambda = data[15:0];
			pe_pkg::REG_MU:        mu = data[15:0];
			pe_pkg::REG_NONCE:     nonce = data;
			default: ;
		endcase
	endfunction

	// Square-and-multiply; operands stay below 2^32 so products fit 64 bits
	function logic [63:0] power_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1 % m;
		base = base % m;
		while (e != 0) begin
			if (e[0])
				acc = (acc * base) % m;
			base = (base * base) % m;
			e = e >> 1;
		end
		return acc;
	endfunction

	function logic [31:0] crypt(pe_pkg::op_t op, logic [31:0] value);
		logic [63:0] n, nsq, x, m_red, res;
		n = 64'(modulus) & ((64'd1 << pe_pkg::DEF_MOD_WIDTH) - 64'd1);
		if (n == 0)
			return 32'd0;
		nsq = n * n;
		if (op == pe_pkg::OP_ENC) begin
			res = (power_mod(64'(generator), 64'(value), nsq)
				* power_mod(64'(nonce), n, nsq)) % nsq;
		end else begin
			x = power_mod(64'(value), 64'(lambda), nsq);
			m_red = 64'(mu) % n;
			// a zero power floors L to -1
			if (x == 0)
				res = (n - m_red) % n;
			else
				res = (((x - 64'd1) / n) * m_red) % n;
		end
		return res[31:0];
	endfunction

	function void note_input(pe_pkg::op_t op, logic [31:0] value);
		expected_results.push_back(crypt(op, value));
	endfunction

	function void check_result(logic [31:0] result);
		logic [31:0] want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h", result);
			return;
		end
		want = expected_results.pop_front();
		if (result !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected %h actual %h", want, result);
		end
	endfunction

	function int pending();
		return expected_results.size();
	endfunction
endclass

module tb_top;
	import pe_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic calm;
	int ready_hold;

	pe_in_if in_ch();
	pe_out_if out_ch();

	paillier_scoreboard sb;

	paillier_encrypt_decrypt dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Stall the result side in short bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold > 0) begin
			out_ch.ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			out_ch.ready <= 1'b0;
			ready_hold <= $urandom_range(0, 3);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Check each result transfer
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.result);
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	// Drop valid, hold until every result has come, then let the block settle
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_keys(logic [15:0] n, logic [31:0] g, logic [15:0] lam,
			logic [15:0] m, logic [31:0] r);
		wait_idle();
		write_reg(REG_MODULUS, {16'($urandom), n});
		write_reg(REG_GENERATOR, g);
		write_reg(REG_LAMBDA, {16'($urandom), lam});
		write_reg(REG_MU, {16'($urandom), m});
		write_reg(REG_NONCE, r);
		cfg_we <= 1'b0;
	endtask

	// Valid stays high between back-to-back items; only an idle burst lowers it
	task automatic send(op_t op, logic [31:0] value);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.value <= value;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(op, value);
	endtask

	// Mostly short plaintexts keep encrypt latency down; decrypts mostly below n^2
	task automatic send_random(int count);
		logic [63:0] nsq;
		logic [31:0] v;
		for (int i = 0; i < count; i++) begin
			nsq = 64'(sb.modulus) * 64'(sb.modulus);
			if ($urandom_range(0, 1) == 0) begin
				v = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 255);
				send(OP_ENC, v);
			end else begin
				v = $urandom;
				if (nsq != 0 && $urandom_range(0, 4) != 0)
					v = 32'(64'(v) % nsq);
				send(OP_DEC, v);
			end
		end
	endtask

	initial begin
		#100_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = 1'b0;
		in_ch.value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset keys
		send(OP_ENC, 32'd0);
		send(OP_ENC, 32'd1);
		send(OP_ENC, 32'd42);
		send(OP_ENC, 32'hFFFF_FFFF);
		send(OP_DEC, sb.crypt(OP_ENC, 32'd42));
		send(OP_DEC, 32'd0);
		send(OP_DEC, 32'd1);
		send(OP_DEC, 32'hFFFF_FFFF);
		send(OP_DEC, 32'd3233 * 32'd3233);
		send_random(90);

		// Top of every register
		load_keys(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send(OP_ENC, 32'hFFFF_FFFF);
		send(OP_DEC, 32'hFFFF_FFFF);
		send_random(90);

		// Smallest keys, zero generator, zero nonce
		load_keys(16'd2, 32'd0, 16'd1, 16'd0, 32'd0);
		send(OP_ENC, 32'd0);
		send(OP_DEC, 32'd0);
		send(OP_DEC, 32'd2);
		send_random(60);

		// Unit modulus makes everything zero mod 1
		load_keys(16'd1, 32'd5, 16'd3, 16'd7, 32'd9);
		send(OP_ENC, 32'd0);
		send(OP_DEC, 32'd3);
		send_random(30);

		// Zero modulus gives zero results
		load_keys(16'd0, $urandom, 16'd100, 16'd55, $urandom);
		send(OP_ENC, 32'd77);
		send(OP_DEC, 32'd77);
		send_random(30);

		// Small textbook keys: 11 * 13
		load_keys(16'd143, 32'd144, 16'd60, 16'd31, 32'd23);
		send_random(100);

		// Random keys
		load_keys(16'($urandom), $urandom, 16'($urandom_range(1, 65535)),
			16'($urandom), $urandom);
		send_random(90);

		// Reset keys again with no idling
		load_keys(RST_MODULUS, RST_GENERATOR, RST_LAMBDA, RST_MU, RST_NONCE);
		calm = 1'b1;
		send_random(100);
		in_ch.valid <= 1'b0;

		wait_idle();
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/pe_pkg.sv
sv/pe_stream_if.sv
sv/pe_modmul.sv
sv/paillier_encrypt_decrypt.sv
test/tb_top.sv
